### src/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// Shared constants, operation and status codes, and transaction types of the
// generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

    localparam int SLOT_COUNT = 256;
    localparam int GEN_WIDTH  = 32;
    localparam int IDX_WIDTH  = $clog2(SLOT_COUNT);
    localparam int CNT_WIDTH  = $clog2(SLOT_COUNT + 1);

    localparam logic [1:0] OP_ALLOCATE = 2'd0;
    localparam logic [1:0] OP_RELEASE  = 2'd1;
    localparam logic [1:0] OP_LOOKUP   = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]           operation;
        logic [IDX_WIDTH-1:0] slot_index;
        logic [GEN_WIDTH-1:0] slot_generation;
    } ght_cmd_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [IDX_WIDTH-1:0] handle_index;
        logic [GEN_WIDTH-1:0] handle_generation;
    } ght_result_t;

    typedef struct packed {
        logic                 alive;
        logic [GEN_WIDTH-1:0] generation;
    } ght_slot_t;

endpackage

### src/generational_handle_table.sv
// ----------------------------------------------------------------------------
// generational_handle_table
// Slot-map allocator: allocate, release and look up generational handles.
//
// Usage: drive command and raise start; a transaction is taken at a clock
// edge where start is high and busy is low. Each transaction gives exactly
// one result, shown on result for one cycle with done high; the receiver
// cannot stall it. Steps from the accepting edge to done:
//   - allocate of a never-used slot, table full, out-of-range handle,
//     unused operation code: result registered at the accepting edge, busy stays low (one per cycle).
//   - release and lookup of an in-range handle: busy in the check state
//     (slot memory read, then compare and write back).
//   - allocate from the free stack: busy in the pop and alloc states (free stack
//     read, then the dependent slot memory read).
// Slot state (alive mark and generation) sits in one synchronous memory and
// the free stack in another; entries at or above the never-used count are
// never used, so no clearing pass is needed. Reset clears the counters and
// the sequencer and the done flag; the block takes a transaction in the first cycle after
// reset.
// ----------------------------------------------------------------------------
module generational_handle_table (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  ght_pkg::ght_cmd_t    command,
    output logic                 busy,
    output logic                 done,
    output ght_pkg::ght_result_t result
);
    import ght_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_POP   = 2'd1;
    localparam logic [1:0] ST_ALLOC = 2'd2;
    localparam logic [1:0] ST_CHECK = 2'd3;

    logic [1:0]           state_reg, state_next;
    ght_cmd_t             cmd_reg, cmd_next;
    logic [IDX_WIDTH-1:0] slot_reg, slot_next;
    logic [CNT_WIDTH-1:0] free_count_reg, free_count_next;
    logic [CNT_WIDTH-1:0] next_unused_reg, next_unused_next;
    logic                 done_reg, done_next;
    ght_result_t          result_reg, result_next;

    ght_slot_t            slot_mem [SLOT_COUNT];
    ght_slot_t            slot_rd_data;
    logic [IDX_WIDTH-1:0] slot_rd_addr;
    logic                 slot_we;
    logic [IDX_WIDTH-1:0] slot_wr_addr;
    ght_slot_t            slot_wr_data;

    logic [IDX_WIDTH-1:0] stack_mem [SLOT_COUNT];
    logic [IDX_WIDTH-1:0] stack_rd_data;
    logic [IDX_WIDTH-1:0] stack_rd_addr;
    logic                 stack_we;
    logic [IDX_WIDTH-1:0] stack_wr_addr;

    logic                 accept;
    logic                 hit;

    assign accept = start && (state_reg == ST_IDLE);
    assign hit    = slot_rd_data.alive && (slot_rd_data.generation == cmd_reg.slot_generation);

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        slot_next        = slot_reg;
        free_count_next  = free_count_reg;
        next_unused_next = next_unused_reg;
        done_next        = 1'b0;
        result_next      = result_reg;
        slot_rd_addr     = command.slot_index;
        slot_we          = 1'b0;
        slot_wr_addr     = cmd_reg.slot_index;
        slot_wr_data     = '{alive: 1'b1, generation: slot_rd_data.generation};
        stack_rd_addr    = IDX_WIDTH'(free_count_reg - 1'b1);
        stack_we         = 1'b0;
        stack_wr_addr    = free_count_reg[IDX_WIDTH-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = command;
                    result_next = '{status: STATUS_INVALID,
                                    handle_index: command.slot_index,
                                    handle_generation: command.slot_generation};
                    unique case (command.operation)
                        OP_ALLOCATE:
                        begin
                            if (free_count_reg != '0)
                            begin
                                state_next = ST_POP;
                            end
                            else if (next_unused_reg < CNT_WIDTH'(SLOT_COUNT))
                            begin
                                slot_we          = 1'b1;
                                slot_wr_addr     = next_unused_reg[IDX_WIDTH-1:0];
                                slot_wr_data     = '{alive: 1'b1, generation: '0};
                                next_unused_next = next_unused_reg + 1'b1;
                                done_next        = 1'b1;
                                result_next      = '{status: STATUS_OK,
                                                     handle_index: next_unused_reg[IDX_WIDTH-1:0],
                                                     handle_generation: '0};
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                result_next = '{status: STATUS_FULL,
                                                handle_index: '0,
                                                handle_generation: '0};
                            end
                        end
                        OP_RELEASE, OP_LOOKUP:
                        begin
                            if ({1'b0, command.slot_index} < next_unused_reg)
                            begin
                                state_next = ST_CHECK;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                slot_rd_addr    = stack_rd_data;
                slot_next       = stack_rd_data;
                free_count_next = free_count_reg - 1'b1;
                state_next      = ST_ALLOC;
            end
            ST_ALLOC:
            begin
                slot_we      = 1'b1;
                slot_wr_addr = slot_reg;
                slot_wr_data = '{alive: 1'b1, generation: slot_rd_data.generation};
                done_next    = 1'b1;
                result_next  = '{status: STATUS_OK,
                                 handle_index: slot_reg,
                                 handle_generation: slot_rd_data.generation};
                state_next   = ST_IDLE;
            end
            ST_CHECK:
            begin
                done_next   = 1'b1;
                result_next = '{status: STATUS_INVALID,
                                handle_index: cmd_reg.slot_index,
                                handle_generation: cmd_reg.slot_generation};
                if (hit)
                begin
                    if (cmd_reg.operation == OP_LOOKUP)
                    begin
                        result_next.status = STATUS_OK;
                    end
                    else if (free_count_reg < CNT_WIDTH'(SLOT_COUNT))
                    begin
                        slot_we            = 1'b1;
                        slot_wr_addr       = cmd_reg.slot_index;
                        slot_wr_data       = '{alive: 1'b0,
                                               generation: slot_rd_data.generation + 1'b1};
                        stack_we           = 1'b1;
                        free_count_next    = free_count_reg + 1'b1;
                        result_next.status = STATUS_OK;
                    end
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            free_count_reg  <= '0;
            next_unused_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            free_count_reg  <= free_count_next;
            next_unused_reg <= next_unused_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        slot_reg   <= slot_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wr_addr] <= slot_wr_data;
        end
        slot_rd_data <= slot_mem[slot_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_wr_addr] <= cmd_reg.slot_index;
        end
        stack_rd_data <= stack_mem[stack_rd_addr];
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_free_le_used: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= next_unused_reg)
        else $error("free stack holds more slots than were ever used");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (result_reg.status == STATUS_FULL)) |->
        ((next_unused_reg == CNT_WIDTH'(SLOT_COUNT)) && (free_count_reg == '0)))
        else $error("table full reported while a slot is available");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (done_reg || busy))
        else $error("accepted transaction neither completed nor in progress");

    a_pop_then_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |=> ((state_reg == ST_ALLOC) &&
        (free_count_reg == $past(free_count_reg) - 1'b1)))
        else $error("free stack pop did not advance to slot read");

endmodule

### tb/tb_generational_handle_table.sv
// ----------------------------------------------------------------------------
// tb_generational_handle_table
// Self-checking bench for the generational handle table. Directed tests cover
// empty-table handles, allocate and release cycles and free-stack reuse.
// Random traffic then fills and drains the table with live, stale and junk
// handles. A local slot-map predictor computes each result when the command
// is taken, and a checker compares every done strobe with the oldest result
// still pending.
// ----------------------------------------------------------------------------
module tb_generational_handle_table;

    timeunit 1ns;
    timeprecision 1ps;

    import ght_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;
    localparam int STALE_DEPTH = 32;

    typedef struct packed {
        logic [IDX_WIDTH-1:0] idx;
        logic [GEN_WIDTH-1:0] gen;
    } handle_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    ght_cmd_t    command;
    logic        busy;
    logic        done;
    ght_result_t result;

    bit                   slot_alive [SLOT_COUNT];
    logic [GEN_WIDTH-1:0] slot_gen [SLOT_COUNT];
    logic [IDX_WIDTH-1:0] free_slots [SLOT_COUNT];
    int                   free_depth;
    int                   fresh_slots;

    ght_result_t pending_results[$];
    handle_t     live_handles[$];
    handle_t     stale_handles[$];
    int          mismatch_count;
    bit          growing;
    int          full_hits;
    bit          quiet_stretch;

    generational_handle_table dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic bit handle_is_live(input logic [IDX_WIDTH-1:0] idx,
                                          input logic [GEN_WIDTH-1:0] gen);
        return (int'(idx) < fresh_slots) && slot_alive[idx] && (slot_gen[idx] == gen);
    endfunction

    function automatic ght_result_t table_apply(input ght_cmd_t cmd);
        ght_result_t r;
        int          slot;
        bit          got;
        r.status            = STATUS_INVALID;
        r.handle_index      = cmd.slot_index;
        r.handle_generation = cmd.slot_generation;
        got                 = 1'b1;
        slot                = 0;
        case (cmd.operation)
            OP_ALLOCATE:
            begin
                if (free_depth > 0)
                begin
                    free_depth--;
                    slot = free_slots[free_depth];
                end
                else if (fresh_slots < SLOT_COUNT)
                begin
                    slot = fresh_slots;
                    fresh_slots++;
                end
                else
                    got = 1'b0;
                if (got)
                begin
                    slot_alive[slot]    = 1'b1;
                    r.status            = STATUS_OK;
                    r.handle_index      = IDX_WIDTH'(slot);
                    r.handle_generation = slot_gen[slot];
                end
                else
                begin
                    r.status            = STATUS_FULL;
                    r.handle_index      = '0;
                    r.handle_generation = '0;
                end
            end
            OP_RELEASE:
            begin
                if (handle_is_live(cmd.slot_index, cmd.slot_generation))
                begin
                    slot_alive[cmd.slot_index] = 1'b0;
                    slot_gen[cmd.slot_index]   = slot_gen[cmd.slot_index] + 1'b1;
                    free_slots[free_depth]     = cmd.slot_index;
                    free_depth++;
                    r.status = STATUS_OK;
                end
            end
            OP_LOOKUP:
            begin
                if (handle_is_live(cmd.slot_index, cmd.slot_generation))
                    r.status = STATUS_OK;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic void track_handles(input ght_cmd_t cmd, input ght_result_t r);
        handle_t h;
        if (cmd.operation == OP_ALLOCATE && r.status == STATUS_OK)
        begin
            h.idx = r.handle_index;
            h.gen = r.handle_generation;
            live_handles.insert(live_handles.size(), h);
        end
        else if (cmd.operation == OP_ALLOCATE && r.status == STATUS_FULL)
        begin
            full_hits++;
            if (full_hits >= 3)
            begin
                growing   = 1'b0;
                full_hits = 0;
            end
        end
        else if (cmd.operation == OP_RELEASE && r.status == STATUS_OK)
        begin
            for (int i = 0; i < live_handles.size(); i++)
            begin
                if (live_handles[i].idx == cmd.slot_index)
                begin
                    live_handles.delete(i);
                    break;
                end
            end
            h.idx = cmd.slot_index;
            h.gen = cmd.slot_generation;
            stale_handles.insert(stale_handles.size(), h);
            if (stale_handles.size() > STALE_DEPTH)
                void'(stale_handles.pop_front());
        end
        if (!growing && live_handles.size() < 4)
            growing = 1'b1;
    endfunction

    function automatic ght_cmd_t make_cmd(input logic [1:0] op,
                                          input logic [IDX_WIDTH-1:0] idx,
                                          input logic [GEN_WIDTH-1:0] gen);
        ght_cmd_t c;
        c.operation       = op;
        c.slot_index      = idx;
        c.slot_generation = gen;
        return c;
    endfunction

    task automatic send_command(input ght_cmd_t cmd);
        int          gap;
        ght_result_t r;
        if ($urandom_range(0, 39) == 0)
            quiet_stretch = !quiet_stretch;
        gap = quiet_stretch ? 0 : $urandom_range(0, 6);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start   <= 1'b1;
        command <= cmd;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        r = table_apply(cmd);
        pending_results.insert(pending_results.size(), r);
        track_handles(cmd, r);
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        ght_result_t want;
        if (done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: status %0d index %0d generation %h",
                             result.status, result.handle_index, result.handle_generation);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status
                    || result.handle_index !== want.handle_index
                    || result.handle_generation !== want.handle_generation)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch at %0t: expected %0d/%0d/%h, got %0d/%0d/%h",
                                 $realtime, want.status, want.handle_index,
                                 want.handle_generation, result.status,
                                 result.handle_index, result.handle_generation);
                end
            end
        end
    end

    task automatic test_empty_table();
        send_command(make_cmd(OP_LOOKUP, 8'd0, 32'd0));
        send_command(make_cmd(OP_RELEASE, 8'd0, 32'd0));
        send_command(make_cmd(OP_LOOKUP, 8'd255, 32'hFFFF_FFFF));
        send_command(make_cmd(OP_UNUSED, 8'd255, 32'hFFFF_FFFF));
        send_command(make_cmd(OP_RELEASE, 8'd255, 32'hFFFF_FFFF));
    endtask

    task automatic test_allocate_release();
        send_command(make_cmd(OP_ALLOCATE, 8'd255, 32'hFFFF_FFFF));
        send_command(make_cmd(OP_ALLOCATE, 8'd0, 32'd0));
        send_command(make_cmd(OP_LOOKUP, 8'd0, 32'd0));
        send_command(make_cmd(OP_LOOKUP, 8'd0, 32'd1));
        send_command(make_cmd(OP_LOOKUP, 8'd1, 32'hFFFF_FFFF));
        send_command(make_cmd(OP_RELEASE, 8'd0, 32'd0));
        send_command(make_cmd(OP_RELEASE, 8'd0, 32'd0));
        send_command(make_cmd(OP_LOOKUP, 8'd0, 32'd0));
        send_command(make_cmd(OP_ALLOCATE, 8'd17, 32'h5A5A_5A5A));
        send_command(make_cmd(OP_LOOKUP, 8'd0, 32'd1));
        send_command(make_cmd(OP_RELEASE, 8'd1, 32'd0));
        send_command(make_cmd(OP_RELEASE, 8'd0, 32'd1));
        send_command(make_cmd(OP_ALLOCATE, 8'd0, 32'd0));
        send_command(make_cmd(OP_ALLOCATE, 8'd0, 32'd0));
        send_command(make_cmd(OP_ALLOCATE, 8'd0, 32'd0));
        send_command(make_cmd(OP_LOOKUP, 8'd2, 32'd0));
        send_command(make_cmd(OP_LOOKUP, 8'd3, 32'd0));
        send_command(make_cmd(OP_UNUSED, 8'd2, 32'd0));
    endtask

    function automatic ght_cmd_t pick_random_command();
        ght_cmd_t c;
        handle_t  h;
        int       roll;
        int       alloc_pct;
        int       release_pct;
        c.operation       = OP_ALLOCATE;
        c.slot_index      = IDX_WIDTH'($urandom);
        c.slot_generation = $urandom;
        roll        = $urandom_range(0, 99);
        alloc_pct   = growing ? 70 : 10;
        release_pct = growing ? 10 : 70;
        if (roll < alloc_pct)
            c.operation = OP_ALLOCATE;
        else if (roll < alloc_pct + release_pct + 8)
        begin
            c.operation = (roll < alloc_pct + release_pct) ? OP_RELEASE : OP_LOOKUP;
            if (live_handles.size() != 0)
            begin
                h = live_handles[$urandom_range(0, live_handles.size() - 1)];
                c.slot_index      = h.idx;
                c.slot_generation = h.gen;
            end
        end
        else if (roll < alloc_pct + release_pct + 14)
        begin
            c.operation = $urandom_range(0, 1) ? OP_RELEASE : OP_LOOKUP;
            if (stale_handles.size() != 0)
            begin
                h = stale_handles[$urandom_range(0, stale_handles.size() - 1)];
                c.slot_index      = h.idx;
                c.slot_generation = h.gen;
            end
        end
        else
        begin
            c.operation = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 1))
                c.slot_generation = $urandom_range(0, 3);
        end
        return c;
    endfunction

    task automatic test_random_traffic(input int count);
        for (int n = 0; n < count; n++)
        begin
            send_command(pick_random_command());
            if ($urandom_range(0, 149) == 0)
                wait_results_drained();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        command        = '0;
        mismatch_count = 0;
        free_depth     = 0;
        fresh_slots    = 0;
        growing        = 1'b1;
        full_hits      = 0;
        quiet_stretch  = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_alive[i] = 1'b0;
            slot_gen[i]   = '0;
            free_slots[i] = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        wait_results_drained();
        test_allocate_release();
        wait_results_drained();
        test_random_traffic(1250);
        wait_results_drained();

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
